// ===== rtl/wlsc_pkg.sv =====
// Package for the strong-Wolfe line search step controller.
// Phase and status codes, register indexes, field widths and the config struct.
// No dependencies.
`default_nettype none
package wlsc_pkg;

   localparam int STEP_W   = 32;
   localparam int VALUE_W  = 32;
   localparam int FACTOR_W = 17;
   localparam int LIMIT_W  = 8;
   localparam int STATUS_W = 3;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_BRACKET = 2'd1;
   localparam logic [PHASE_W-1:0] PH_ZOOM    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_EVALUATE  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BRACKET_LIMIT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ZOOM_LIMIT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ASCENT    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PRECISION = 3'd5;

   localparam logic OP_START    = 1'b0;
   localparam logic OP_EVALUATE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DECREASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVATURE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd2;

   localparam logic [FACTOR_W-1:0] DECREASE_RESET  = 17'd7;
   localparam logic [FACTOR_W-1:0] CURVATURE_RESET = 17'd58982;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 8'd20;

   localparam logic [STEP_W-1:0] ONE_STEP = 32'h0001_0000;

   typedef struct packed {
      logic [FACTOR_W-1:0] decrease_factor;
      logic [FACTOR_W-1:0] curvature_factor;
      logic [LIMIT_W-1:0]  iteration_limit;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/wlsc_if.sv =====
// Valid/ready channel interfaces for the step controller: request and response.
// Depends on wlsc_pkg.
`default_nettype none
interface wlsc_req_if;
   import wlsc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic signed [VALUE_W-1:0] objective_value;
   logic signed [VALUE_W-1:0] directional_slope;

   modport source (output valid, output operation, output objective_value,
                   output directional_slope, input ready);
   modport sink   (input valid, input operation, input objective_value,
                   input directional_slope, output ready);
endinterface

interface wlsc_rsp_if;
   import wlsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [STEP_W-1:0]   trial_step;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output trial_step, output status, input ready);
   modport sink   (input valid, input trial_step, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/wolfe_line_search_step_control.sv =====
// Top level of the strong-Wolfe line search step controller: input stage,
// result register and configuration port. Depends on wlsc_pkg, wlsc_if,
// wlsc_csr and wlsc_core.
//
//  channel    dir  handshake          payload
//  req_chan   in   valid/ready        operation, objective_value, directional_slope
//  rsp_chan   out  valid/ready        trial_step, status
//  csr_*      in   write enable only  index, write data (17 bits)
//
// One transaction per clock sustained while rsp_chan.ready stays high; an accepted
// request passes through the input register, then the combinational step update,
// and an emitted result waits in the result register until taken. Synchronous reset
// clears the stage valids and the search phase and reloads the configuration
// defaults. req_chan.ready falls only while the input register holds an item and
// a result waits untaken.
`default_nettype none
module wolfe_line_search_step_control
   import wlsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   wlsc_req_if.sink                  req_chan,
   wlsc_rsp_if.source                rsp_chan,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FACTOR_W-1:0]  csr_write_data
);

   cfg_type cfg;

   logic                      in_valid_ff, in_valid_in;
   logic                      operation_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] slope_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]         trial_step_ff;
   logic [STATUS_W-1:0]       status_ff;

   logic                      fire;
   logic                      accept;
   logic                      emit;
   logic [STEP_W-1:0]         trial_step;
   logic [STATUS_W-1:0]       status;

   wlsc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wlsc_core u_core (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .operation         (operation_ff),
      .objective_value   (value_ff),
      .directional_slope (slope_ff),
      .cfg               (cfg),
      .emit              (emit),
      .trial_step        (trial_step),
      .status            (status)
   );

   assign fire           = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         operation_ff <= req_chan.operation;
         value_ff     <= req_chan.objective_value;
         slope_ff     <= req_chan.directional_slope;
      end
      if (fire && emit) begin
         trial_step_ff <= trial_step;
         status_ff     <= status;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.trial_step = trial_step_ff;
   assign rsp_chan.status     = status_ff;

   // a held request is not dropped while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(slope_ff) && $stable(value_ff))
      else $error("held request lost during stall");

   // a pending result is never overwritten before it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !fire)
      else $error("result register overwritten while stalled");

   // the input stage always drains when the result side is free
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_valid_ff |-> fire)
      else $error("input stage stalled with free result register");

endmodule
`default_nettype wire

// ===== rtl/wlsc_csr.sv =====
// Configuration registers of the step controller: write-only, reset to defaults.
// Depends on wlsc_pkg.
`default_nettype none
module wlsc_csr
   import wlsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FACTOR_W-1:0]  csr_write_data,
   output      cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DECREASE:  cfg_in.decrease_factor  = csr_write_data;
            CSR_CURVATURE: cfg_in.curvature_factor = csr_write_data;
            CSR_LIMIT:     cfg_in.iteration_limit  = csr_write_data[LIMIT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decrease_factor  <= DECREASE_RESET;
         cfg_ff.curvature_factor <= CURVATURE_RESET;
         cfg_ff.iteration_limit  <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/wlsc_core.sv =====
// Search state and combinational step update of the line search controller.
// Depends on wlsc_pkg; driven by the input stage of the top level.
`default_nettype none
module wlsc_core
   import wlsc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      fire,
   input  wire logic                      operation,
   input  wire logic signed [VALUE_W-1:0] objective_value,
   input  wire logic signed [VALUE_W-1:0] directional_slope,
   input  wire cfg_type                   cfg,
   output      logic                      emit,
   output      logic [STEP_W-1:0]         trial_step,
   output      logic [STATUS_W-1:0]       status
);

   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic [STEP_W-1:0]         current_step_ff, current_step_in;
   logic [STEP_W-1:0]         low_step_ff, low_step_in;
   logic [STEP_W-1:0]         high_step_ff, high_step_in;
   logic signed [VALUE_W-1:0] initial_value_ff, initial_value_in;
   logic signed [VALUE_W-1:0] low_value_ff, low_value_in;
   logic [STEP_W-1:0]         decrease_mag_ff, decrease_mag_in;   // -decrease_threshold
   logic [STEP_W-1:0]         curvature_ff, curvature_in;
   logic [LIMIT_W-1:0]        count_ff, count_in;

   // start arithmetic
   logic [VALUE_W-1:0]          slope_mag;
   logic [VALUE_W+FACTOR_W-1:0] dec_prod, curv_prod;
   logic [VALUE_W+FACTOR_W:0]   dec_round;
   logic [VALUE_W+FACTOR_W-16:0] dec_q;
   logic [VALUE_W+FACTOR_W-17:0] curv_q;

   // evaluation arithmetic
   logic signed [VALUE_W:0]     value_diff;
   logic signed [2*STEP_W:0]    lhs_ext, sum;
   logic [2*STEP_W-1:0]         rhs_prod;
   logic                        above;
   logic [VALUE_W-1:0]          abs_slope;
   logic                        curv_ok;
   logic                        slope_neg, slope_zero;
   logic [STEP_W:0]             doubled;
   logic [STEP_W:0]             mid_sum;
   logic                        same_sign;
   logic                        do_mid;

   always_comb begin
      slope_neg  = directional_slope[VALUE_W-1];
      slope_zero = (directional_slope == '0);
      slope_mag  = VALUE_W'(-directional_slope);
      dec_prod   = slope_mag * cfg.decrease_factor;
      curv_prod  = slope_mag * cfg.curvature_factor;
      dec_round  = {1'b0, dec_prod} + (VALUE_W+FACTOR_W+1)'(16'hFFFF);
      dec_q      = dec_round[VALUE_W+FACTOR_W:16];
      curv_q     = curv_prod[VALUE_W+FACTOR_W-1:16];

      // f - f0 scaled by 2^16 against step * threshold, exact in 65 bits
      value_diff = {objective_value[VALUE_W-1], objective_value}
                 - {initial_value_ff[VALUE_W-1], initial_value_ff};
      lhs_ext    = (2*STEP_W+1)'(value_diff) <<< 16;
      rhs_prod   = current_step_ff * decrease_mag_ff;
      sum        = lhs_ext + $signed({1'b0, rhs_prod});
      above      = !sum[2*STEP_W] && (sum != '0);
      abs_slope  = slope_neg ? slope_mag : directional_slope;
      curv_ok    = abs_slope <= curvature_ff;
      doubled    = {current_step_ff, 1'b0};
   end

   always_comb begin
      phase_in         = phase_ff;
      current_step_in  = current_step_ff;
      low_step_in      = low_step_ff;
      high_step_in     = high_step_ff;
      initial_value_in = initial_value_ff;
      low_value_in     = low_value_ff;
      decrease_mag_in  = decrease_mag_ff;
      curvature_in     = curvature_ff;
      count_in         = count_ff;
      emit             = 1'b0;
      trial_step       = current_step_ff;
      status           = ST_EVALUATE;
      do_mid           = 1'b0;
      same_sign        = 1'b0;
      mid_sum          = '0;

      if (operation == OP_START) begin
         emit = 1'b1;
         if (!slope_neg && !slope_zero) begin
            phase_in   = PH_IDLE;
            trial_step = '0;
            status     = ST_ASCENT;
         end else begin
            decrease_mag_in  = (dec_q > (VALUE_W+FACTOR_W-15)'(33'h1_0000_0000 >> 1))
                             ? STEP_W'(33'h1_0000_0000 >> 1) : dec_q[STEP_W-1:0];
            curvature_in     = (curv_q[VALUE_W+FACTOR_W-17:STEP_W] != '0)
                             ? '1 : curv_q[STEP_W-1:0];
            initial_value_in = objective_value;
            low_value_in     = objective_value;
            low_step_in      = '0;
            high_step_in     = '0;
            count_in         = '0;
            current_step_in  = ONE_STEP;
            phase_in         = PH_BRACKET;
            trial_step       = ONE_STEP;
         end
      end else if (phase_ff == PH_BRACKET || phase_ff == PH_ZOOM) begin
         emit = 1'b1;
         if (count_ff >= cfg.iteration_limit) begin
            status   = (phase_ff == PH_ZOOM) ? ST_ZOOM_LIMIT : ST_BRACKET_LIMIT;
            phase_in = PH_IDLE;
         end else begin
            count_in = LIMIT_W'(count_ff + LIMIT_W'(1));
            if (phase_ff == PH_BRACKET) begin
               if (above || (low_step_ff != '0 && objective_value >= low_value_ff)) begin
                  high_step_in = current_step_ff;
                  phase_in     = PH_ZOOM;
                  do_mid       = 1'b1;
               end else if (curv_ok) begin
                  phase_in = PH_IDLE;
                  status   = ST_ACCEPTED;
               end else begin
                  high_step_in = low_step_ff;
                  low_step_in  = current_step_ff;
                  low_value_in = objective_value;
                  if (!slope_neg) begin
                     phase_in = PH_ZOOM;
                     do_mid   = 1'b1;
                  end else begin
                     current_step_in = doubled[STEP_W] ? '1 : doubled[STEP_W-1:0];
                     trial_step      = current_step_in;
                  end
               end
            end else begin
               if (above || objective_value >= low_value_ff) begin
                  if (current_step_ff == high_step_ff) begin
                     phase_in = PH_IDLE;
                     status   = ST_PRECISION;
                  end else begin
                     high_step_in = current_step_ff;
                     do_mid       = 1'b1;
                  end
               end else if (curv_ok) begin
                  phase_in = PH_IDLE;
                  status   = ST_ACCEPTED;
               end else begin
                  same_sign = slope_zero || (high_step_ff == low_step_ff)
                            || (!slope_neg && high_step_ff > low_step_ff)
                            || (slope_neg && high_step_ff < low_step_ff);
                  if (same_sign) begin
                     high_step_in = low_step_ff;
                  end
                  if (current_step_ff == low_step_ff) begin
                     phase_in = PH_IDLE;
                     status   = ST_PRECISION;
                  end else begin
                     low_step_in  = current_step_ff;
                     low_value_in = objective_value;
                     do_mid       = 1'b1;
                  end
               end
            end
            if (do_mid) begin
               mid_sum         = {1'b0, low_step_in} + {1'b0, high_step_in};
               current_step_in = mid_sum[STEP_W:1];
               trial_step      = current_step_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         current_step_ff  <= current_step_in;
         low_step_ff      <= low_step_in;
         high_step_ff     <= high_step_in;
         initial_value_ff <= initial_value_in;
         low_value_ff     <= low_value_in;
         decrease_mag_ff  <= decrease_mag_in;
         curvature_ff     <= curvature_in;
      end
   end

   // an evaluation while idle leaves no trace
   assert property (@(posedge clock) disable iff (reset)
      fire && operation == OP_EVALUATE && phase_ff == PH_IDLE |-> !emit)
      else $error("evaluation while idle produced a result");

   // a descent start always opens the bracket phase with the count cleared
   assert property (@(posedge clock) disable iff (reset)
      fire && operation == OP_START && (slope_neg || slope_zero)
      |=> phase_ff == PH_BRACKET && count_ff == '0)
      else $error("start did not open bracket phase");

   // any terminal status ends the search
   assert property (@(posedge clock) disable iff (reset)
      fire && emit && status != ST_EVALUATE |=> phase_ff == PH_IDLE)
      else $error("search still active after terminal status");

   // stalls freeze the search state
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(count_ff))
      else $error("search state moved without a transaction");

endmodule
`default_nettype wire
